// ===== hw/rtl/skht_pkg.sv =====
// Shared types and constants for the string key hash table.
package skht_pkg;

    localparam int TABLE_SIZE   = 4093;
    localparam int SLOT_W       = $clog2(TABLE_SIZE);
    localparam int LIMIT        = (TABLE_SIZE + 1) / 2;
    localparam int STEP_W       = $clog2(LIMIT + 1);
    localparam int KEY_BYTES    = 20;
    localparam int KEY_W        = 8 * KEY_BYTES;
    localparam int VALUE_W      = 16;
    localparam int SLOT_OUT_W   = 12;
    localparam int HASH_W       = 32;
    localparam int REDUCE_STEPS = HASH_W / 2;
    localparam int CNT_W        = $clog2(KEY_BYTES);
    localparam int QDEPTH       = 2;

    localparam logic [HASH_W-1:0] HASH_MASK = 32'h7FFF_FFFF;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        action_t             action;
        logic [63:0]         key_low;
        logic [63:0]         key_mid;
        logic [31:0]         key_top;
        logic [VALUE_W-1:0]  new_value;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [VALUE_W-1:0]    value;
    } rsp_t;

    // One classified operation, handed from the front to the back.
    typedef struct packed {
        action_t             action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [SLOT_W-1:0]   home;
    } work_t;

endpackage

// ===== hw/rtl/skht_front.sv =====
// Front end: accepts a transaction, normalizes the key, hashes it and finds the home slot.
module skht_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clearing,
    input  logic              req_valid,
    output logic              req_ready,
    input  skht_pkg::req_t    req,
    output logic              push_valid,
    input  logic              push_ready,
    output skht_pkg::work_t   push_data
);

    localparam int REM_W = skht_pkg::SLOT_W + 2;
    localparam logic [REM_W-1:0] P1 = REM_W'(skht_pkg::TABLE_SIZE);
    localparam logic [REM_W-1:0] P2 = REM_W'(2 * skht_pkg::TABLE_SIZE);
    localparam logic [REM_W-1:0] P3 = REM_W'(3 * skht_pkg::TABLE_SIZE);

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_HASH   = 4'b0010,
        F_REDUCE = 4'b0100,
        F_PUSH   = 4'b1000
    } fstate_t;

    fstate_t                          state_reg, state_next;
    logic [skht_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             ended_reg, ended_next;
    logic [skht_pkg::HASH_W-1:0]      h_reg, h_next;
    logic [skht_pkg::SLOT_W-1:0]      rem_reg, rem_next;
    logic [skht_pkg::KEY_W-1:0]       key_reg, key_next;
    skht_pkg::action_t                action_reg, action_next;
    logic [skht_pkg::VALUE_W-1:0]     value_reg, value_next;

    logic [7:0]                       cur_byte;
    logic                             ended_now;
    logic [7:0]                       norm_byte;
    logic [skht_pkg::HASH_W-1:0]      h_step;
    logic [REM_W-1:0]                 rem4;
    logic [REM_W-1:0]                 rem_red;

    assign cur_byte  = key_reg[7:0];
    assign ended_now = ended_reg || (cur_byte == 8'd0);
    assign norm_byte = ended_now ? 8'd0 : cur_byte;
    assign h_step    = ended_now ? h_reg
                     : (h_reg << 5) - h_reg + {24'd0, cur_byte};

    // Two remainder bits per cycle: rem*4 + d stays below 4P.
    assign rem4 = {rem_reg, h_reg[skht_pkg::HASH_W-1 -: 2]};
    always_comb
    begin
        if (rem4 >= P3)
        begin
            rem_red = rem4 - P3;
        end
        else if (rem4 >= P2)
        begin
            rem_red = rem4 - P2;
        end
        else if (rem4 >= P1)
        begin
            rem_red = rem4 - P1;
        end
        else
        begin
            rem_red = rem4;
        end
    end

    assign req_ready  = (state_reg == F_IDLE) && !clearing;
    assign push_valid = (state_reg == F_PUSH);

    always_comb
    begin
        push_data.action = action_reg;
        push_data.key    = key_reg;
        push_data.value  = value_reg;
        push_data.home   = rem_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ended_next  = ended_reg;
        h_next      = h_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        action_next = action_reg;
        value_next  = value_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    key_next    = {req.key_top, req.key_mid, req.key_low};
                    action_next = req.action;
                    value_next  = req.new_value;
                    h_next      = '0;
                    ended_next  = 1'b0;
                    cnt_next    = '0;
                    state_next  = F_HASH;
                end
            end
            F_HASH:
            begin
                // Rotate the normalized byte in at the top; after all bytes the key is in place.
                key_next   = {norm_byte, key_reg[skht_pkg::KEY_W-1:8]};
                ended_next = ended_now;
                if (cnt_reg == skht_pkg::CNT_W'(skht_pkg::KEY_BYTES - 1))
                begin
                    h_next     = h_step & skht_pkg::HASH_MASK;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = F_REDUCE;
                end
                else
                begin
                    h_next   = h_step;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            F_REDUCE:
            begin
                rem_next = rem_red[skht_pkg::SLOT_W-1:0];
                h_next   = h_reg << 2;
                if (cnt_reg == skht_pkg::CNT_W'(skht_pkg::REDUCE_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        rem_reg    <= rem_next;
        key_reg    <= key_next;
        action_reg <= action_next;
        value_reg  <= value_next;
    end

endmodule

// ===== hw/rtl/skht_queue.sv =====
// Short queue of classified operations between the front and the back.
module skht_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  skht_pkg::work_t   push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output skht_pkg::work_t   pop_data
);

    localparam int PTR_W = $clog2(skht_pkg::QDEPTH);
    localparam int CNT_W = $clog2(skht_pkg::QDEPTH + 1);

    skht_pkg::work_t   entry_reg [skht_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(skht_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(skht_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(skht_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/skht_back.sv =====
// Back end: clears the valid marks, probes the table and returns one result per operation.
module skht_back (
    input  logic              clk,
    input  logic              rst_n,
    output logic              clearing,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  skht_pkg::work_t   pop_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output skht_pkg::rsp_t    rsp
);

    localparam int SLOT_W = skht_pkg::SLOT_W;
    localparam int STEP_W = skht_pkg::STEP_W;
    localparam int SUM_W  = SLOT_W + 1;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_ISSUE = 4'b0100,
        B_CHECK = 4'b1000
    } bstate_t;

    typedef struct packed {
        logic [skht_pkg::KEY_W-1:0]   key;
        logic [skht_pkg::VALUE_W-1:0] value;
    } entry_t;

    logic   valid_mem [skht_pkg::TABLE_SIZE];
    entry_t data_mem  [skht_pkg::TABLE_SIZE];

    bstate_t             state_reg, state_next;
    logic [SLOT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    skht_pkg::work_t     work_reg, work_next;
    logic                rd_valid_reg;
    entry_t              rd_entry_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    skht_pkg::rsp_t      rsp_reg, rsp_next;

    logic                hit;
    logic                last;
    logic                can_emit;
    logic                emit_req;
    logic                do_write;
    logic [STEP_W:0]     inc;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    sum_wrap;
    entry_t              wr_entry;

    assign clearing  = (state_reg == B_CLEAR);
    assign pop_ready = (state_reg == B_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign hit      = rd_valid_reg && (rd_entry_reg.key == work_reg.key);
    assign last     = (step_reg == STEP_W'(skht_pkg::LIMIT));
    assign can_emit = !rsp_valid_reg || rsp_ready;
    assign emit_req = !rd_valid_reg || hit || last;
    assign do_write = (state_reg == B_CHECK) && !rd_valid_reg
                      && (work_reg.action == skht_pkg::ACT_INSERT) && can_emit;

    // Odd increment 2*step-1; position plus increment stays below twice the table size.
    assign inc      = {step_reg, 1'b0} - 1'b1;
    assign sum      = SUM_W'(pos_reg) + SUM_W'(inc);
    assign sum_wrap = (sum >= SUM_W'(skht_pkg::TABLE_SIZE))
                      ? sum - SUM_W'(skht_pkg::TABLE_SIZE) : sum;

    assign wr_entry.key   = work_reg.key;
    assign wr_entry.value = work_reg.value;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        work_next      = work_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_idx_reg == SLOT_W'(skht_pkg::TABLE_SIZE - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    work_next  = pop_data;
                    pos_next   = pop_data.home;
                    step_next  = STEP_W'(1);
                    state_next = B_ISSUE;
                end
            end
            B_ISSUE:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (emit_req)
                begin
                    // Hold the read data until the output register frees up.
                    if (can_emit)
                    begin
                        rsp_valid_next = 1'b1;
                        state_next     = B_IDLE;
                        if (!rd_valid_reg)
                        begin
                            rsp_next.slot = skht_pkg::SLOT_OUT_W'(pos_reg);
                            if (work_reg.action == skht_pkg::ACT_INSERT)
                            begin
                                rsp_next.status = skht_pkg::ST_INSERTED;
                                rsp_next.value  = work_reg.value;
                            end
                            else
                            begin
                                rsp_next.status = skht_pkg::ST_MISS;
                                rsp_next.value  = '0;
                            end
                        end
                        else if (hit)
                        begin
                            rsp_next.status = skht_pkg::ST_HIT;
                            rsp_next.slot   = skht_pkg::SLOT_OUT_W'(pos_reg);
                            rsp_next.value  = rd_entry_reg.value;
                        end
                        else
                        begin
                            rsp_next.status = skht_pkg::ST_FULL;
                            rsp_next.slot   = '0;
                            rsp_next.value  = '0;
                        end
                    end
                end
                else
                begin
                    pos_next   = sum_wrap[SLOT_W-1:0];
                    step_next  = step_reg + 1'b1;
                    state_next = B_ISSUE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        step_reg <= step_next;
        work_reg <= work_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLEAR)
        begin
            valid_mem[clr_idx_reg] <= 1'b0;
        end
        else if (do_write)
        begin
            valid_mem[pos_reg] <= 1'b1;
        end
        if (do_write)
        begin
            data_mem[pos_reg] <= wr_entry;
        end
        if (state_reg == B_ISSUE)
        begin
            rd_valid_reg <= valid_mem[pos_reg];
            rd_entry_reg <= data_mem[pos_reg];
        end
    end

endmodule

// ===== hw/rtl/string_key_hash_table.sv =====
// String key hash table: lookup and insert of up to 20-byte keys with quadratic probing.
//
// After reset the block clears the valid mark of every slot and holds req_ready low
// meanwhile. Each request then passes through the front end in order: the accept, byte-serial
// hashing of the key, a two-bit-per-cycle remainder by the table size, and the hand-off of
// the operation to a two-entry queue, which waits while the queue is full. The back end picks
// up the operation, then for each slot probed does one single-port read of the slot memories
// and one compare; a table full result is given once LIMIT slots have been probed without a
// hit or a free slot. Front and back overlap, so the front end can take a new request while
// the back end still probes for an earlier one; long probe chains then set the pace.
// Results come out in request order through a registered output.
module string_key_hash_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  skht_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output skht_pkg::rsp_t    rsp
);

    logic              clearing;
    logic              push_valid;
    logic              push_ready;
    skht_pkg::work_t   push_data;
    logic              pop_valid;
    logic              pop_ready;
    skht_pkg::work_t   pop_data;

    skht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clearing   (clearing),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    skht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    skht_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clearing   (clearing),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

// ===== hw/rtl/skht_checker.sv =====
// Port-level checks for the string key hash table, bound to the top level.
module skht_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  skht_pkg::req_t    req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  skht_pkg::rsp_t    rsp
);

    logic [3:0] pending_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Track transactions accepted but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_fire && !rsp_fire)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (rsp_fire && !req_fire)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 4'd0)
        else $error("response without an outstanding request");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == skht_pkg::ST_FULL |-> rsp.slot == '0 && rsp.value == '0)
        else $error("table full result carries slot or value");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.slot) < skht_pkg::TABLE_SIZE)
        else $error("slot beyond table size");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == skht_pkg::ST_MISS |-> rsp.value == '0)
        else $error("lookup miss carries a value");

endmodule

bind string_key_hash_table skht_checker u_skht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
